[design/tdd_pkg.sv]
package tdd_pkg;

    localparam int NUM_DIGITS  = 6;
    localparam int STORE_DEPTH = 6;
    localparam int POS_W       = $clog2(NUM_DIGITS + 1);
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int DP_POS      = 3;

    typedef logic [3:0] code_t;

    localparam code_t CODE_BLANK = 4'hA;
    localparam code_t CODE_C     = 4'hB;
    localparam code_t CODE_DEG   = 4'hC;
    localparam code_t CODE_MINUS = 4'hD;

    localparam logic [7:0] SEL_RESET = 8'h7F;
    localparam logic [7:0] ALL_OFF   = 8'hFF;
    localparam logic [7:0] DP_MASK   = 8'h7F;

    typedef code_t [STORE_DEPTH-1:0] store_t;

    typedef struct packed {
        logic       op;
        logic [15:0] raw_reading;
        logic       sensor_missing;
    } item_t;

    typedef struct packed {
        logic [7:0] digit_enable;
        logic [7:0] segments;
    } disp_t;

    // active-low segments, bit 7 is the decimal point
    function automatic logic [7:0] seg_decode(input code_t code);
        logic [7:0] seg;
        case (code)
            4'd0:       seg = 8'hC0;
            4'd1:       seg = 8'hF9;
            4'd2:       seg = 8'hA4;
            4'd3:       seg = 8'hB0;
            4'd4:       seg = 8'h99;
            4'd5:       seg = 8'h92;
            4'd6:       seg = 8'h82;
            4'd7:       seg = 8'hF8;
            4'd8:       seg = 8'h80;
            4'd9:       seg = 8'h90;
            CODE_C:     seg = 8'hC6;
            CODE_DEG:   seg = 8'h9C;
            CODE_MINUS: seg = 8'hBF;
            default:    seg = ALL_OFF;
        endcase
        return seg;
    endfunction

endpackage

[design/temperature_display_driver.sv]
// Seven-segment temperature display driver, six common-anode digits.
// Input stream: tuser selects the transfer kind (0 = new sensor reading,
// 1 = millisecond scan tick); tdata carries the raw 1/16 degree reading
// and the sensor-missing flag.
// Output stream: one transfer per input transfer, carrying the segment
// and digit-select drive (both active low) after that item is applied.
// A load returns the unchanged drive; ticks step through 'C', degree,
// tenths, ones with point, tens, hundreds, then one all-off slot; a
// tick flagged sensor-missing blanks the drive without stepping.
// The item waits in the input register; the result is offered from
// the drive latches. One transfer per cycle while the receiver takes
// results; the convert and scan logic in between is combinational.
// Reset clears the digit store to zeros, drives all segments and
// digits off and restarts the scan at the 'C' position.
// If the receiver stalls, the output transfer holds and one further
// input is buffered; tready then falls until the output is taken.
module temperature_display_driver
    import tdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // raw_reading[15:0], sensor_missing[16]
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // segments[7:0], digit_enable[15:8]
);

    item_t  item_reg;
    logic   in_valid_reg, in_valid_next;
    logic   out_valid_reg, out_valid_next;
    logic   s_fire;
    logic   advance;
    store_t digits;
    disp_t  disp;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_reg.op             <= s_axis_tuser;
            item_reg.raw_reading    <= s_axis_tdata[15:0];
            item_reg.sensor_missing <= s_axis_tdata[16];
        end
    end

    tdd_convert u_convert (
        .raw_reading (item_reg.raw_reading),
        .digits      (digits)
    );

    tdd_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .digits  (digits),
        .disp    (disp)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {disp.digit_enable, disp.segments};

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("buffered item dropped");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed item produced no result");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled without a full pipeline");

endmodule

[design/tdd_convert.sv]
module tdd_convert
    import tdd_pkg::*;
(
    input  logic [15:0] raw_reading,
    output store_t      digits
);

    logic        neg;
    logic [15:0] mag;
    logic [7:0]  whole;
    logic [7:0]  rem8;
    logic [6:0]  rem;
    logic [1:0]  hund_n;
    logic [14:0] tens_prod;
    logic [3:0]  tens_n;
    logic [3:0]  ones_n;
    logic [6:0]  frac_x5;
    code_t       hund_c;
    code_t       tens_c;

    assign neg   = raw_reading[15];
    assign mag   = neg ? 16'(~raw_reading + 16'd1) : raw_reading;
    assign whole = mag[11:4];

    always_comb
    begin
        if (whole >= 8'd200)
        begin
            hund_n = 2'd2;
            rem8   = whole - 8'd200;
        end
        else if (whole >= 8'd100)
        begin
            hund_n = 2'd1;
            rem8   = whole - 8'd100;
        end
        else
        begin
            hund_n = 2'd0;
            rem8   = whole;
        end
    end

    assign rem = rem8[6:0];

    // x*205 >> 11 is x/10 for x below 100
    assign tens_prod = 15'(rem) * 15'd205;
    assign tens_n    = tens_prod[14:11];
    assign ones_n    = 4'(rem - 7'(tens_n) * 7'd10);

    // floor(frac * 10 / 16)
    assign frac_x5 = 7'(mag[3:0]) * 7'd5;

    always_comb
    begin
        hund_c = code_t'(hund_n);
        tens_c = tens_n;
        if (hund_n == 2'd0)
        begin
            hund_c = CODE_BLANK;
            if (tens_n == 4'd0)
            begin
                tens_c = CODE_BLANK;
            end
        end
        if (neg)
        begin
            hund_c = CODE_MINUS;
        end
    end

    always_comb
    begin
        digits    = '0;
        digits[0] = CODE_C;
        digits[1] = CODE_DEG;
        digits[2] = frac_x5[6:3];
        digits[3] = ones_n;
        digits[4] = tens_c;
        digits[5] = hund_c;
    end

endmodule

[design/tdd_scan.sv]
module tdd_scan
    import tdd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  item_t  item,
    input  store_t digits,
    output disp_t  disp
);

    store_t             store_reg, store_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]         sel_reg, sel_next;
    logic [7:0]         seg_reg, seg_next;
    logic [7:0]         en_reg, en_next;
    logic [7:0]         seg_lookup;

    always_comb
    begin
        seg_lookup = ALL_OFF;
        if (pos_reg < POS_W'(STORE_DEPTH))
        begin
            seg_lookup = seg_decode(store_reg[pos_reg[IDX_W-1:0]]);
        end
        if (pos_reg == POS_W'(DP_POS))
        begin
            seg_lookup = seg_lookup & DP_MASK;
        end
    end

    always_comb
    begin
        store_next = store_reg;
        pos_next   = pos_reg;
        sel_next   = sel_reg;
        seg_next   = seg_reg;
        en_next    = en_reg;
        if (advance)
        begin
            if (!item.op)
            begin
                store_next = digits;
            end
            else if (item.sensor_missing)
            begin
                seg_next = ALL_OFF;
                en_next  = ALL_OFF;
            end
            else if (pos_reg >= POS_W'(NUM_DIGITS))
            begin
                // blanking slot
                pos_next = '0;
                sel_next = SEL_RESET;
                en_next  = ALL_OFF;
            end
            else
            begin
                seg_next = seg_lookup;
                en_next  = sel_reg;
                sel_next = {1'b1, sel_reg[7:1]};
                pos_next = POS_W'(pos_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg <= '0;
            pos_reg   <= '0;
            sel_reg   <= SEL_RESET;
            seg_reg   <= ALL_OFF;
            en_reg    <= ALL_OFF;
        end
        else
        begin
            store_reg <= store_next;
            pos_reg   <= pos_next;
            sel_reg   <= sel_next;
            seg_reg   <= seg_next;
            en_reg    <= en_next;
        end
    end

    assign disp.segments     = seg_reg;
    assign disp.digit_enable = en_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(NUM_DIGITS))
        else $error("scan position out of range");

    a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(~en_reg) <= 1 && $countones(~sel_reg) <= 1)
        else $error("more than one digit selected");

    a_load_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !item.op |=> $stable(en_reg) && $stable(seg_reg))
        else $error("reading load disturbed the drive latches");

endmodule

[test/tdd_tb_pkg.sv]
`timescale 1ns / 1ps

package tdd_tb_pkg;

    // tuser codes on the input stream
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

endpackage

[test/display_checker.sv]
`timescale 1ns / 1ps

module display_checker
    import tdd_pkg::*;
    import tdd_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // raw_reading[15:0], sensor_missing[16]
    input  logic        s_tuser,   // op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // segments[7:0], digit_enable[15:8]
    output int          errors,
    output int          pending
);

    localparam logic [7:0] GLYPH [16] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
        8'h80, 8'h90, 8'hFF, 8'hC6, 8'h9C, 8'hBF, 8'hFF, 8'hFF
    };

    code_t      digits [STORE_DEPTH];
    int         scan_pos;
    logic [7:0] select_pat;
    logic [7:0] seg_latch;
    logic [7:0] en_latch;
    disp_t      drive_q [$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t mismatch %s: got %02h want %02h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic load_reading(input logic [15:0] reading);
        logic       neg;
        logic [15:0] mag;
        int         whole;
        code_t      hund;
        code_t      tens;
        begin
            neg   = reading[15];
            mag   = neg ? 16'(~reading + 16'd1) : reading;
            whole = int'(mag[11:4]);
            hund  = code_t'(whole / 100);
            tens  = code_t'((whole % 100) / 10);
            digits[0] = CODE_C;
            digits[1] = CODE_DEG;
            digits[2] = code_t'((int'(mag[3:0]) * 10) / 16);
            digits[3] = code_t'(whole % 10);
            if (hund == 4'd0)
            begin
                hund = CODE_BLANK;
                if (tens == 4'd0)
                    tens = CODE_BLANK;
            end
            if (neg)
                hund = CODE_MINUS;
            digits[4] = tens;
            digits[5] = hund;
        end
    endtask

    task automatic scan_step(input logic missing);
        logic [7:0] glyph;
        begin
            if (missing)
            begin
                seg_latch = ALL_OFF;
                en_latch  = ALL_OFF;
            end
            else if (scan_pos >= NUM_DIGITS)
            begin
                scan_pos   = 0;
                select_pat = SEL_RESET;
                en_latch   = ALL_OFF;
            end
            else
            begin
                glyph = (scan_pos < STORE_DEPTH) ? GLYPH[digits[scan_pos]] : ALL_OFF;
                if (scan_pos == DP_POS)
                    glyph = glyph & DP_MASK;
                seg_latch  = glyph;
                en_latch   = select_pat;
                select_pat = {1'b1, select_pat[7:1]};
                scan_pos++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        disp_t want;
        disp_t got;
        if (!rst_n)
        begin
            foreach (digits[i])
                digits[i] = 4'd0;
            scan_pos   = 0;
            select_pat = SEL_RESET;
            seg_latch  = ALL_OFF;
            en_latch   = ALL_OFF;
            drive_q.delete();
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = disp_t'(m_tdata);
                if (drive_q.size() == 0)
                    report_mismatch("transfer with nothing pending", got.segments, ALL_OFF);
                else
                begin
                    want = drive_q.pop_front();
                    if (got.segments !== want.segments)
                        report_mismatch("segments", got.segments, want.segments);
                    if (got.digit_enable !== want.digit_enable)
                        report_mismatch("digit_enable", got.digit_enable, want.digit_enable);
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == OP_LOAD)
                    load_reading(s_tdata[15:0]);
                else
                    scan_step(s_tdata[16]);
                want.segments     = seg_latch;
                want.digit_enable = en_latch;
                drive_q.push_back(want);
            end
            pending = drive_q.size();
        end
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import tdd_pkg::*;
    import tdd_tb_pkg::*;

    localparam int ITEM_COUNT = 1250;
    localparam int HOLD_AT    = 700;
    localparam int HOLD_LEN   = 300;

    logic        clk;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [23:0] s_data  = '0;
    logic        s_user  = OP_LOAD;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_data;
    logic        calm    = 1'b0;
    int          errors;
    int          pending;
    int          sent    = 0;

    temperature_display_driver u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data)
    );

    display_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_valid),
        .s_tready (s_ready),
        .s_tdata  (s_data),
        .s_tuser  (s_user),
        .m_tvalid (m_valid),
        .m_tready (m_ready),
        .m_tdata  (m_data),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // sink side; one long hold-off so the block backs up
    initial
    begin : sink
        int cycle;
        cycle = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cycle++;
            if (cycle == HOLD_AT)
            begin
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                cycle += HOLD_LEN;
            end
            else
                m_ready <= calm || ($urandom_range(0, 99) >= 14);
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input logic kind, input logic [15:0] reading,
                             input logic missing);
        if (!calm && $urandom_range(0, 99) < 14)
        begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= kind;
        s_data  <= {7'd0, missing, reading};
        do
            @(posedge clk);
        while (!s_ready);
        sent++;
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_reading();
        int deg;
        if ($urandom_range(0, 1) == 0)
            return 16'($urandom_range(0, 65535));
        deg = $urandom_range(0, 180) - 55;
        return 16'(deg * 16 + $urandom_range(0, 15));
    endfunction

    initial
    begin : stimulus
        logic [15:0] rd;
        int          n;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // cleared store, full scan with blanking slot
        repeat (7) send_item(OP_TICK, 16'h0000, 1'b0);
        // largest positive
        send_item(OP_LOAD, 16'h7FFF, 1'b0);
        repeat (7) send_item(OP_TICK, 16'hFFFF, 1'b0);
        // most negative, then a missing sensor mid-scan
        send_item(OP_LOAD, 16'h8000, 1'b1);
        repeat (4) send_item(OP_TICK, 16'h0000, 1'b0);
        send_item(OP_TICK, 16'h0000, 1'b1);
        repeat (2) send_item(OP_TICK, 16'h0000, 1'b0);
        send_item(OP_LOAD, 16'hFFFF, 1'b0);
        send_item(OP_LOAD, 16'h0000, 1'b0);
        send_item(OP_LOAD, 16'h00A0, 1'b0);

        while (sent < ITEM_COUNT)
        begin
            calm = (sent >= 150 && sent < 350);
            if (sent >= 1000 && sent < 1020)
            begin
                s_valid <= 1'b0;
                do
                    @(negedge clk);
                while (pending != 0);
            end
            if ($urandom_range(0, 99) < 80)
            begin
                send_item(OP_LOAD, pick_reading(), 1'($urandom_range(0, 1)));
                n = $urandom_range(6, 15);
                repeat (n)
                    send_item(OP_TICK, 16'($urandom_range(0, 65535)),
                              $urandom_range(0, 99) < 5);
            end
            else
            begin
                rd = 16'($urandom_range(0, 65535));
                send_item(1'($urandom_range(0, 1)), rd, $urandom_range(0, 99) < 30);
            end
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
